/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent at the next clock edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/rsa_mexp_pkg.sv */
package rsa_mexp_pkg;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_MODULUS          = 2'd0;
   localparam csr_index_type REG_PUBLIC_EXPONENT  = 2'd1;
   localparam csr_index_type REG_PRIVATE_EXPONENT = 2'd2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_MULT,
      ST_SQUARE,
      ST_DONE
   } state_type;

endpackage

/* sv/rsa_block_modexp.sv */
// RSA block modular exponentiation, result = block_value ^ e mod modulus.
// Request channel (req_valid, req_stall, req_opcode, req_block_value): opcode
// encrypt selects the public exponent, decrypt the private exponent.
// Result channel (rsp_valid, rsp_stall, rsp_result_value): one transfer per
// request. Configuration (csr_write_enable, csr_index, csr_write_data) sets
// modulus, public and private exponent; index 3 is ignored.
// One item is worked on at a time; req_stall is high while an item is in work.
// A single bit-serial modular multiplier does one multiplier bit per cycle.
// The base is reduced first, then each exponent bit from the lowest up to the
// highest set bit takes a scan step, a multiply of the accumulator by the base
// when the bit is set, and a squaring of the base. A modulus below 2 gives 0.
// The result sits in an output register: while the receiver stalls it holds,
// and a new request is already taken; a further result waits until it leaves.
// Synchronous reset empties the output register, returns to idle and sets
// modulus 2 and both exponents 1.
module rsa_block_modexp
   import rsa_mexp_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [WIDTH-1:0]    req_block_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WIDTH-1:0]    rsp_result_value,
   input  logic                csr_write_enable,
   input  csr_index_type       csr_index,
   input  logic [WIDTH-1:0]    csr_write_data
);

`include "assert_macros.svh"

   localparam int CNT_W = $clog2(WIDTH);

   state_type state_ff, state_in;

   logic [WIDTH-1:0] modulus_ff, pub_exp_ff, priv_exp_ff;
   logic [WIDTH-1:0] exp_ff, acc_ff, x_ff;
   logic [WIDTH-1:0] mul_b_ff, mul_r_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic [WIDTH-1:0] rsp_value_ff;

   logic             req_xfer, degenerate, mul_last, mul_run;
   logic             mul_load, acc_init, acc_from_mul, x_from_mul, exp_shift, rsp_load;
   logic [WIDTH-1:0] mul_a, mul_b_load, mul_dbl, mul_step;

   // (x + y) mod m for x, y below m
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH:0]   s;
      logic [WIDTH+1:0] d;
      s = {1'b0, x} + {1'b0, y};
      d = {1'b0, s} - {2'b00, m};
      add_mod = d[WIDTH+1] ? s[WIDTH-1:0] : d[WIDTH-1:0];
   endfunction

   assign req_xfer   = req_valid && !req_stall;
   assign degenerate = (modulus_ff[WIDTH-1:1] == '0);
   assign mul_last   = (cnt_ff == CNT_W'(WIDTH - 1));
   assign req_stall  = (state_ff != ST_IDLE);

   // multiplier step: double, then add a when the current bit of b is set
   always_comb begin
      case (state_ff)
         ST_REDUCE: mul_a = WIDTH'(1);
         ST_MULT:   mul_a = acc_ff;
         default:   mul_a = x_ff;
      endcase
      mul_dbl  = add_mod(mul_r_ff, mul_r_ff, modulus_ff);
      mul_step = mul_b_ff[WIDTH-1] ? add_mod(mul_dbl, mul_a, modulus_ff) : mul_dbl;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = degenerate ? ST_DONE : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mul_last) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_run      = 1'b0;
      mul_load     = 1'b0;
      mul_b_load   = x_ff;
      acc_init     = 1'b0;
      acc_from_mul = 1'b0;
      x_from_mul   = 1'b0;
      exp_shift    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            acc_init   = req_xfer;
            mul_load   = req_xfer;
            mul_b_load = req_block_value;
         end
         ST_REDUCE: begin
            mul_run    = 1'b1;
            x_from_mul = mul_last;
         end
         ST_SCAN: begin
            mul_load = (exp_ff != '0);
         end
         ST_MULT: begin
            mul_run      = 1'b1;
            acc_from_mul = mul_last;
            mul_load     = mul_last;
         end
         ST_SQUARE: begin
            mul_run    = 1'b1;
            x_from_mul = mul_last;
            exp_shift  = mul_last;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            mul_run = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= WIDTH'(2);
         pub_exp_ff   <= WIDTH'(1);
         priv_exp_ff  <= WIDTH'(1);
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_MODULUS:          modulus_ff  <= csr_write_data;
               REG_PUBLIC_EXPONENT:  pub_exp_ff  <= csr_write_data;
               REG_PRIVATE_EXPONENT: priv_exp_ff <= csr_write_data;
               default:              ;
            endcase
         end
         if (mul_load || (mul_run && mul_last)) begin
            cnt_ff <= '0;
         end else if (mul_run) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         mul_b_ff <= mul_b_load;
         mul_r_ff <= '0;
      end else if (mul_run) begin
         mul_b_ff <= {mul_b_ff[WIDTH-2:0], 1'b0};
         mul_r_ff <= mul_step;
      end
      if (acc_init) begin
         acc_ff <= degenerate ? '0 : WIDTH'(1);
         exp_ff <= (req_opcode == OP_DECRYPT) ? priv_exp_ff : pub_exp_ff;
      end else begin
         if (acc_from_mul) begin
            acc_ff <= mul_step;
         end
         if (exp_shift) begin
            exp_ff <= {1'b0, exp_ff[WIDTH-1:1]};
         end
      end
      if (x_from_mul) begin
         x_ff <= mul_step;
      end
      if (rsp_load) begin
         rsp_value_ff <= acc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   `ASSERT_ALWAYS(a_partial_below_modulus, clock, reset,
      !(state_ff == ST_MULT || state_ff == ST_SQUARE) || (mul_r_ff < modulus_ff))
   `ASSERT_ALWAYS(a_scan_counter_clear, clock, reset,
      (state_ff != ST_SCAN) || (cnt_ff == '0))
   `ASSERT_NEXT(a_degenerate_gives_zero, clock, reset,
      req_xfer && degenerate, (state_ff == ST_DONE) && (acc_ff == '0))
   `ASSERT_NEXT(a_result_from_done, clock, reset,
      !rsp_valid_ff && (state_ff != ST_DONE), !rsp_valid_ff)

endmodule
